>>> hdl/mono_framebuffer_rect_fill_page_read_macros.svh
// Assertion macros shared by the frame store RTL.
`ifndef MONO_FRAMEBUFFER_RECT_FILL_PAGE_READ_MACROS_SVH
`define MONO_FRAMEBUFFER_RECT_FILL_PAGE_READ_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define MFB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define MFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MFB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define MFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> hdl/mfb_pkg.sv
// Types and constants shared by the frame store modules.
`default_nettype none

package mfb_pkg;

  // Frame geometry.
  localparam int ROWS      = 32;
  localparam int COLS      = 128;
  localparam int PAGE_ROWS = 8;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLS);
  localparam int K_W       = $clog2(PAGE_ROWS);

  // Input field widths.
  localparam int OP_W     = 2;
  localparam int COL_IN_W = 9;
  localparam int ROW_IN_W = 7;
  localparam int PAGE_W   = 2;
  localparam int BYTE_W   = 8;

  // Command queue depth.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Opcodes on the command port.
  typedef enum logic [OP_W-1:0] {
    OP_FILL  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Work kinds that reach the back end.
  typedef enum logic [1:0] {
    KIND_FILL,
    KIND_CLEAR,
    KIND_READ
  } kind_e;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_FILL,
    S_READ
  } back_state_e;

  // One classified command, with the rectangle already clipped.
  typedef struct packed {
    kind_e              kind;
    logic [COL_W-1:0]   c_lo;
    logic [COL_W-1:0]   c_hi;
    logic [ROW_W-1:0]   r_lo;
    logic [ROW_W-1:0]   r_hi;
    logic [PAGE_W-1:0]  page;
    logic [COL_W-1:0]   column;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/mfb_front.sv
// Front end: takes commands, clips rectangles and drops work that changes nothing.
`default_nettype none

module mfb_front (
  input  logic                              start,
  output logic                              busy,
  input  logic [mfb_pkg::OP_W-1:0]          op_i,
  input  logic signed [mfb_pkg::COL_IN_W-1:0] left_i,
  input  logic signed [mfb_pkg::ROW_IN_W-1:0] top_i,
  input  logic signed [mfb_pkg::COL_IN_W-1:0] right_i,
  input  logic signed [mfb_pkg::ROW_IN_W-1:0] bottom_i,
  input  logic [mfb_pkg::PAGE_W-1:0]        page_i,
  input  logic [mfb_pkg::COL_W-1:0]         column_i,
  input  logic                              fifo_full_i,
  input  logic                              init_busy_i,
  output logic                              push_o,
  output mfb_pkg::cmd_t                     cmd_o
);
  import mfb_pkg::*;

  logic [COL_IN_W-1:0] c_lo_u;
  logic [COL_IN_W-1:0] c_hi_u;
  logic [ROW_IN_W-1:0] r_lo_u;
  logic [ROW_IN_W-1:0] r_hi_u;
  logic                empty_rect;
  logic                keep;
  logic                accept;

  // New commands are held off while the queue is full or the clearing pass after reset runs.
  assign busy   = fifo_full_i | init_busy_i;
  assign accept = start & ~busy;

  // Clip the rectangle to the frame; negative lows clamp to zero, highs to the edge.
  always_comb begin
    c_lo_u = left_i[COL_IN_W-1] ? '0 : COL_IN_W'(left_i);
    if (right_i[COL_IN_W-1]) begin
      c_hi_u = '0;
    end else if (COL_IN_W'(right_i) > COL_IN_W'(COLS - 1)) begin
      c_hi_u = COL_IN_W'(COLS - 1);
    end else begin
      c_hi_u = COL_IN_W'(right_i);
    end
    r_lo_u = top_i[ROW_IN_W-1] ? '0 : ROW_IN_W'(top_i);
    if (bottom_i[ROW_IN_W-1]) begin
      r_hi_u = '0;
    end else if (ROW_IN_W'(bottom_i) > ROW_IN_W'(ROWS - 1)) begin
      r_hi_u = ROW_IN_W'(ROWS - 1);
    end else begin
      r_hi_u = ROW_IN_W'(bottom_i);
    end
    // A negative high edge or crossed edges leave nothing to draw.
    empty_rect = right_i[COL_IN_W-1] | bottom_i[ROW_IN_W-1] |
                 (c_lo_u > c_hi_u) | (r_lo_u > r_hi_u);
  end

  // Classify the opcode into a back end command.
  always_comb begin
    cmd_o.kind   = KIND_READ;
    cmd_o.c_lo   = c_lo_u[COL_W-1:0];
    cmd_o.c_hi   = c_hi_u[COL_W-1:0];
    cmd_o.r_lo   = r_lo_u[ROW_W-1:0];
    cmd_o.r_hi   = r_hi_u[ROW_W-1:0];
    cmd_o.page   = page_i;
    cmd_o.column = column_i;
    keep         = 1'b0;
    case (op_i)
      OP_FILL: begin
        cmd_o.kind = KIND_FILL;
        keep       = ~empty_rect;
      end
      OP_CLEAR: begin
        cmd_o.kind = KIND_CLEAR;
        keep       = 1'b1;
      end
      OP_READ: begin
        cmd_o.kind = KIND_READ;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = accept & keep;

endmodule

`default_nettype wire

>>> hdl/mfb_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
`include "mono_framebuffer_rect_fill_page_read_macros.svh"

module mfb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  mfb_pkg::cmd_t wr_data_i,
  output logic          full_o,
  output logic          rd_valid_o,
  input  logic          rd_en_i,
  output mfb_pkg::cmd_t rd_data_o
);
  import mfb_pkg::*;

  cmd_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = entry_q[rd_ptr_q];

  // Pointer and fill count update for each transfer in and out.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // The front end never writes into a full queue, and the back end never pops an empty one.
  `MFB_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, wr_en_i, !full_o, "command queue overflow")
  `MFB_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, rd_en_i, rd_valid_o, "command queue underflow")
  `MFB_ASSERT_IMPL(a_count_range, clk_i, rst_ni, 1'b1,
                   count_q <= FIFO_CNT_W'(FIFO_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

>>> hdl/mfb_back.sv
// Back end: frame store memory and the sequencer that fills, clears and reads it row by row.
`default_nettype none
`include "mono_framebuffer_rect_fill_page_read_macros.svh"

module mfb_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  mfb_pkg::cmd_t                cmd_i,
  output logic                         cmd_pop_o,
  output logic                         init_busy_o,
  output logic                         result_valid_o,
  output logic [mfb_pkg::BYTE_W-1:0]   page_byte_o
);
  import mfb_pkg::*;

  back_state_e       state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [K_W-1:0]    k_q, k_d;
  logic              init_q, init_d;
  cmd_t              cmd_q, cmd_d;

  logic              wr_clr;
  logic              wr_set;
  logic              rd_en;
  logic [COLS-1:0]   set_mask;

  logic [COLS-1:0]   store_q [ROWS];
  logic [COLS-1:0]   rd_data_q;
  logic              cap_q;
  logic [K_W-1:0]    cap_k_q;
  logic [BYTE_W-2:0] byte_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] page_byte_q;
  logic              pix;

  assign init_busy_o    = init_q;
  assign result_valid_o = out_valid_q;
  assign page_byte_o    = page_byte_q;

  // Sequencer: one store row per cycle for every kind of command.
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    k_d       = k_q;
    init_d    = init_q;
    cmd_d     = cmd_q;
    cmd_pop_o = 1'b0;
    wr_clr    = 1'b0;
    wr_set    = 1'b0;
    rd_en     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          k_d       = '0;
          case (cmd_i.kind)
            KIND_FILL: begin
              row_d   = cmd_i.r_lo;
              state_d = S_FILL;
            end
            KIND_CLEAR: begin
              row_d   = '0;
              state_d = S_CLEAR;
            end
            KIND_READ: begin
              row_d   = ROW_W'({cmd_i.page, K_W'(0)});
              state_d = S_READ;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        wr_clr = 1'b1;
        if (row_q == ROW_W'(ROWS - 1)) begin
          state_d = S_IDLE;
          init_d  = 1'b0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      S_FILL: begin
        wr_set = 1'b1;
        if (row_q == cmd_q.r_hi) begin
          state_d = S_IDLE;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      S_READ: begin
        rd_en = 1'b1;
        if (k_q == K_W'(PAGE_ROWS - 1)) begin
          state_d = S_IDLE;
        end else begin
          k_d   = k_q + 1'b1;
          row_d = row_q + 1'b1;
        end
      end
    endcase
  end

  // Reset starts a clearing pass over the whole store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      row_q   <= '0;
      k_q     <= '0;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      k_q     <= k_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  // Columns covered by the clipped rectangle.
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      set_mask[c] = (COL_W'(c) >= cmd_q.c_lo) && (COL_W'(c) <= cmd_q.c_hi);
    end
  end

  // Frame store: one row written or read per cycle, with bit-masked set writes.
  always_ff @(posedge clk_i) begin
    if (wr_clr) begin
      store_q[row_q] <= '0;
    end else if (wr_set) begin
      for (int c = 0; c < COLS; c++) begin
        if (set_mask[c]) begin
          store_q[row_q][c] <= 1'b1;
        end
      end
    end
    if (rd_en) begin
      rd_data_q <= store_q[row_q];
    end
  end

  // Pick the addressed column out of each row read back.
  assign pix = rd_data_q[cmd_q.column];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= rd_en;
      out_valid_q <= cap_q && (cap_k_q == K_W'(PAGE_ROWS - 1));
    end
  end

  // Assemble the page byte; the last pixel completes it and raises the strobe.
  always_ff @(posedge clk_i) begin
    cap_k_q <= k_q;
    if (cap_q) begin
      if (cap_k_q == K_W'(PAGE_ROWS - 1)) begin
        page_byte_q <= {pix, byte_q};
      end else begin
        byte_q[cap_k_q] <= pix;
      end
    end
  end

  // A read steps through all rows of a page, so result strobes never come in adjacent cycles.
  `MFB_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, out_valid_q, !out_valid_q,
                   "result strobe held for two cycles")
  `MFB_ASSERT_IMPL(a_fill_in_rect, clk_i, rst_ni, state_q == S_FILL,
                   row_q <= cmd_q.r_hi, "fill row beyond rectangle")
  `MFB_ASSERT_IMPL(a_pop_when_idle, clk_i, rst_ni, cmd_pop_o,
                   (state_q == S_IDLE) && !init_q, "command taken while busy")

endmodule

`default_nettype wire

>>> hdl/mono_framebuffer_rect_fill_page_read.sv
// Top level of the monochrome frame store with rectangle fill and page-byte readout.
//
//   Channel   Handshake                 Payload
//   command   start / busy              op_i, left_i, top_i, right_i, bottom_i, page_i, column_i
//   result    result_valid_o (strobe)   page_byte_o
//
// After reset the store is cleared one row per cycle; busy stays high until that pass ends.
// A fill is taken from the queue while idle and then sets its clipped rows in turn, top to bottom.
// A clear walks every row; a read walks its page's rows, each registered before it joins the byte.
// The single-port row memory sets the rate; a two-entry queue lets the port take commands
// while the back end works, and after that first pass busy is high only while it is full.
// Results are strobed for one cycle and cannot be held off by the receiver.
`default_nettype none

module mono_framebuffer_rect_fill_page_read (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [mfb_pkg::OP_W-1:0]            op_i,
  input  logic signed [mfb_pkg::COL_IN_W-1:0] left_i,
  input  logic signed [mfb_pkg::ROW_IN_W-1:0] top_i,
  input  logic signed [mfb_pkg::COL_IN_W-1:0] right_i,
  input  logic signed [mfb_pkg::ROW_IN_W-1:0] bottom_i,
  input  logic [mfb_pkg::PAGE_W-1:0]          page_i,
  input  logic [mfb_pkg::COL_W-1:0]           column_i,
  output logic                                result_valid_o,
  output logic [mfb_pkg::BYTE_W-1:0]          page_byte_o
);
  import mfb_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic fifo_full;
  logic fifo_valid;
  cmd_t fifo_cmd;
  logic pop;
  logic init_busy;

  // Command intake and classification.
  mfb_front u_front (
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .left_i      (left_i),
    .top_i       (top_i),
    .right_i     (right_i),
    .bottom_i    (bottom_i),
    .page_i      (page_i),
    .column_i    (column_i),
    .fifo_full_i (fifo_full),
    .init_busy_i (init_busy),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Decoupling queue.
  mfb_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_data_i  (push_cmd),
    .full_o     (fifo_full),
    .rd_valid_o (fifo_valid),
    .rd_en_i    (pop),
    .rd_data_o  (fifo_cmd)
  );

  // Store and row sequencer.
  mfb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (fifo_valid),
    .cmd_i          (fifo_cmd),
    .cmd_pop_o      (pop),
    .init_busy_o    (init_busy),
    .result_valid_o (result_valid_o),
    .page_byte_o    (page_byte_o)
  );

endmodule

`default_nettype wire
